/* design/nfps_pkg.sv */
// Package for the NEC frame pulse sequencer: shared constants, register
// indexes, configuration and result structs and the saturating subtract.
// No dependencies.
package nfps_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int DATA_BITS = 4 * BITS_PER_BYTE;
    localparam int BIT_IDX_W = $clog2(DATA_BITS);
    localparam int SEG_W = 6;
    localparam int DUR_W = 18;
    localparam int TIME_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [DUR_W-1:0] REPEAT_STOP_US = DUR_W'(560);
    localparam logic [DUR_W-1:0] GAP_TRIM_US = DUR_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MARK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE = 3'd7;

    localparam logic [TIME_W-1:0] HEADER_MARK_RST = TIME_W'(9000);
    localparam logic [TIME_W-1:0] HEADER_SPACE_RST = TIME_W'(4500);
    localparam logic [TIME_W-1:0] BIT_MARK_RST = TIME_W'(560);
    localparam logic [TIME_W-1:0] ONE_SPACE_RST = TIME_W'(1690);
    localparam logic [TIME_W-1:0] ZERO_SPACE_RST = TIME_W'(560);
    localparam logic [DUR_W-1:0] FRAME_PERIOD_RST = DUR_W'(108000);
    localparam logic [TIME_W-1:0] REPEAT_MARK_RST = TIME_W'(9000);
    localparam logic [TIME_W-1:0] REPEAT_SPACE_RST = TIME_W'(2250);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] header_mark_us;
        logic [TIME_W-1:0] header_space_us;
        logic [TIME_W-1:0] bit_mark_us;
        logic [TIME_W-1:0] one_space_us;
        logic [TIME_W-1:0] zero_space_us;
        logic [DUR_W-1:0]  frame_period_us;
        logic [TIME_W-1:0] repeat_mark_us;
        logic [TIME_W-1:0] repeat_space_us;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [7:0] address_byte;
        logic [7:0] address_check_byte;
        logic [7:0] code_byte;
        logic [7:0] code_check_byte;
        logic [7:0] repeat_count;
    } item_t;

    typedef struct packed {
        logic             carrier_on;
        logic [DUR_W-1:0] duration_us;
        logic             timer_arm;
        logic             done_res;
        logic             busy_error;
    } seg_t;

    function automatic logic [DUR_W-1:0] sat_sub(input logic [DUR_W-1:0] a,
                                                 input logic [DUR_W:0] b);
        logic [DUR_W-1:0] diff;
        diff = a - b[DUR_W-1:0];
        return ({1'b0, a} > b) ? diff : '0;
    endfunction

endpackage

/* design/nfps_seq.sv */
// Segment sequencer of the NEC frame pulse sequencer: frame state and the
// registered result stage. Depends on nfps_pkg.
module nfps_seq
    import nfps_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  take,
    input  item_t item,
    input  logic  out_ready,
    output logic  can_take,
    output logic  res_valid,
    output seg_t  res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DATA,
        PH_REPEAT
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             in_space_half_reg, in_space_half_next;
    logic [SEG_W-1:0] segment_count_reg, segment_count_next;
    logic [31:0]      frame_bytes_reg, frame_bytes_next;
    logic [7:0]       repeats_left_reg, repeats_left_next;
    logic [DUR_W-1:0] period_reg, period_next;
    logic             res_valid_reg;
    seg_t             res_reg, res_next;
    logic             emit;
    logic [7:0]       repeats_dec;
    logic [DUR_W-1:0] bit_space;

    assign can_take = !res_valid_reg || out_ready;
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign repeats_dec = repeats_left_reg - 8'd1;
    assign bit_space = frame_bytes_reg[segment_count_reg[BIT_IDX_W-1:0]]
                       ? DUR_W'(cfg.one_space_us) : DUR_W'(cfg.zero_space_us);

    always_comb begin
        phase_next = phase_reg;
        in_space_half_next = in_space_half_reg;
        segment_count_next = segment_count_reg;
        frame_bytes_next = frame_bytes_reg;
        repeats_left_next = repeats_left_reg;
        period_next = period_reg;
        res_next = '0;
        emit = 1'b1;
        if (item.command == CMD_START) begin
            if (phase_reg != PH_IDLE) begin
                res_next.busy_error = 1'b1;
            end else begin
                frame_bytes_next = {item.code_check_byte, item.code_byte,
                                    item.address_check_byte, item.address_byte};
                repeats_left_next = item.repeat_count;
                in_space_half_next = 1'b0;
                segment_count_next = '0;
                period_next = cfg.frame_period_us;
                phase_next = PH_HEADER;
                res_next.carrier_on = 1'b1;
                res_next.duration_us = DUR_W'(cfg.header_mark_us);
                res_next.timer_arm = 1'b1;
            end
        end else begin
            res_next.timer_arm = 1'b1;
            case (phase_reg)
                PH_HEADER: begin
                    period_next = sat_sub(period_reg, {3'b000, cfg.header_mark_us}
                                                      + {3'b000, cfg.header_space_us});
                    phase_next = PH_DATA;
                    in_space_half_next = 1'b0;
                    segment_count_next = '0;
                    res_next.duration_us = DUR_W'(cfg.header_space_us);
                end
                PH_DATA: begin
                    if (!in_space_half_reg) begin
                        in_space_half_next = 1'b1;
                        period_next = sat_sub(period_reg, (DUR_W+1)'(cfg.bit_mark_us));
                        res_next.carrier_on = 1'b1;
                        res_next.duration_us = DUR_W'(cfg.bit_mark_us);
                    end else if (segment_count_reg < SEG_W'(DATA_BITS)) begin
                        segment_count_next = segment_count_reg + SEG_W'(1);
                        in_space_half_next = 1'b0;
                        period_next = sat_sub(period_reg, {1'b0, bit_space});
                        res_next.duration_us = bit_space;
                    end else begin
                        in_space_half_next = 1'b0;
                        segment_count_next = '0;
                        if (repeats_left_reg != 8'd0) begin
                            res_next.duration_us = sat_sub(period_reg, {1'b0, GAP_TRIM_US});
                            period_next = cfg.frame_period_us;
                            phase_next = PH_REPEAT;
                        end else begin
                            phase_next = PH_IDLE;
                            repeats_left_next = '0;
                            period_next = cfg.frame_period_us;
                            res_next.timer_arm = 1'b0;
                            res_next.done_res = 1'b1;
                        end
                    end
                end
                PH_REPEAT: begin
                    case (segment_count_reg[1:0])
                        2'd0: begin
                            segment_count_next = SEG_W'(1);
                            period_next = sat_sub(period_reg, (DUR_W+1)'(cfg.repeat_mark_us));
                            res_next.carrier_on = 1'b1;
                            res_next.duration_us = DUR_W'(cfg.repeat_mark_us);
                        end
                        2'd1: begin
                            segment_count_next = SEG_W'(2);
                            period_next = sat_sub(period_reg,
                                                  (DUR_W+1)'(cfg.repeat_space_us));
                            res_next.duration_us = DUR_W'(cfg.repeat_space_us);
                        end
                        2'd2: begin
                            segment_count_next = SEG_W'(3);
                            period_next = sat_sub(period_reg, {1'b0, REPEAT_STOP_US});
                            res_next.carrier_on = 1'b1;
                            res_next.duration_us = REPEAT_STOP_US;
                        end
                        default: begin
                            repeats_left_next = repeats_dec;
                            period_next = cfg.frame_period_us;
                            segment_count_next = '0;
                            if (repeats_dec != 8'd0) begin
                                res_next.duration_us = period_reg;
                            end else begin
                                phase_next = PH_IDLE;
                                in_space_half_next = 1'b0;
                                res_next.timer_arm = 1'b0;
                                res_next.done_res = 1'b1;
                            end
                        end
                    endcase
                end
                default: begin
                    emit = 1'b0;
                    res_next.timer_arm = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            in_space_half_reg <= 1'b0;
            segment_count_reg <= '0;
            repeats_left_reg <= '0;
            period_reg <= FRAME_PERIOD_RST;
            res_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                in_space_half_reg <= in_space_half_next;
                segment_count_reg <= segment_count_next;
                frame_bytes_reg <= frame_bytes_next;
                repeats_left_reg <= repeats_left_next;
                period_reg <= period_next;
            end
            if (take && emit) begin
                res_reg <= res_next;
                res_valid_reg <= 1'b1;
            end else if (out_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/nec_frame_pulse_sequencer.sv */
// NEC frame pulse sequencer top level: configuration registers, input
// register and the segment sequencer. Depends on nfps_pkg and nfps_seq.
// An accepted transaction passes the input register and then the result register to the outputs.
// Throughput: one transaction per cycle while m_ready does not stall the result, set by the input and result registers.
// Reset: synchronous, active low; control and configuration registers return to their defaults, idle.
module nec_frame_pulse_sequencer
    import nfps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DUR_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [7:0]           s_address_byte,
    input  logic [7:0]           s_address_check_byte,
    input  logic [7:0]           s_code_byte,
    input  logic [7:0]           s_code_check_byte,
    input  logic [7:0]           s_repeat_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_carrier_on,
    output logic [DUR_W-1:0]     m_duration_us,
    output logic                 m_timer_arm,
    output logic                 m_done_res,
    output logic                 m_busy_error
);

    cfg_t  cfg_reg;
    logic  in_valid_reg;
    item_t item_reg;
    logic  can_take;
    logic  take;
    seg_t  res;

    assign take = in_valid_reg && can_take;
    assign s_ready = !in_valid_reg || can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_mark_us <= HEADER_MARK_RST;
            cfg_reg.header_space_us <= HEADER_SPACE_RST;
            cfg_reg.bit_mark_us <= BIT_MARK_RST;
            cfg_reg.one_space_us <= ONE_SPACE_RST;
            cfg_reg.zero_space_us <= ZERO_SPACE_RST;
            cfg_reg.frame_period_us <= FRAME_PERIOD_RST;
            cfg_reg.repeat_mark_us <= REPEAT_MARK_RST;
            cfg_reg.repeat_space_us <= REPEAT_SPACE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEADER_MARK: cfg_reg.header_mark_us <= cfg_wr_data[TIME_W-1:0];
                REG_HEADER_SPACE: cfg_reg.header_space_us <= cfg_wr_data[TIME_W-1:0];
                REG_BIT_MARK: cfg_reg.bit_mark_us <= cfg_wr_data[TIME_W-1:0];
                REG_ONE_SPACE: cfg_reg.one_space_us <= cfg_wr_data[TIME_W-1:0];
                REG_ZERO_SPACE: cfg_reg.zero_space_us <= cfg_wr_data[TIME_W-1:0];
                REG_FRAME_PERIOD: cfg_reg.frame_period_us <= cfg_wr_data;
                REG_REPEAT_MARK: cfg_reg.repeat_mark_us <= cfg_wr_data[TIME_W-1:0];
                REG_REPEAT_SPACE: cfg_reg.repeat_space_us <= cfg_wr_data[TIME_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                item_reg <= '{command: s_command,
                              address_byte: s_address_byte,
                              address_check_byte: s_address_check_byte,
                              code_byte: s_code_byte,
                              code_check_byte: s_code_check_byte,
                              repeat_count: s_repeat_count};
            end else if (can_take) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    nfps_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .take      (take),
        .item      (item_reg),
        .out_ready (m_ready),
        .can_take  (can_take),
        .res_valid (m_valid),
        .res       (res)
    );

    assign m_carrier_on = res.carrier_on;
    assign m_duration_us = res.duration_us;
    assign m_timer_arm = res.timer_arm;
    assign m_done_res = res.done_res;
    assign m_busy_error = res.busy_error;

endmodule

/* design/nfps_checker.sv */
// Port checker for the NEC frame pulse sequencer and its bind statement.
// Depends on nfps_pkg and nec_frame_pulse_sequencer.
module nfps_port_checker
    import nfps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_wr_en,
    input logic [CFG_IDX_W-1:0] cfg_addr,
    input logic [DUR_W-1:0]     cfg_wr_data,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_command,
    input logic [7:0]           s_address_byte,
    input logic [7:0]           s_address_check_byte,
    input logic [7:0]           s_code_byte,
    input logic [7:0]           s_code_check_byte,
    input logic [7:0]           s_repeat_count,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_carrier_on,
    input logic [DUR_W-1:0]     m_duration_us,
    input logic                 m_timer_arm,
    input logic                 m_done_res,
    input logic                 m_busy_error
);

    // A stalled result transaction stays valid and keeps its duration, carrier and done fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duration_us)
                                && $stable(m_carrier_on) && $stable(m_done_res))
        else $error("stalled result changed");

    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // A refused start carries nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_busy_error |-> !m_carrier_on && !m_timer_arm && !m_done_res
                                    && m_duration_us == '0)
        else $error("busy error result is not clean");

    // Only a finish or a refused start leaves the timer unarmed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_timer_arm |-> (m_done_res || m_busy_error) && !m_carrier_on)
        else $error("timer left unarmed in an ordinary segment");

endmodule

bind nec_frame_pulse_sequencer nfps_port_checker u_checker (.*);
